>>> rtl/vcp_pkg.sv
// ----------------------------------------------------------------------------
// vcp_pkg
// Shared constants and types of the variable-width code packer.
// ----------------------------------------------------------------------------
`default_nettype none

package vcp_pkg;

   localparam int VALUE_BITS       = 16;
   localparam int WIDTH_FIELD_BITS = 5;
   localparam int BYTE_BITS        = 8;
   localparam int MAX_CODE_BITS    = 16;
   localparam int WIDTH_LIMIT      = (MAX_CODE_BITS < VALUE_BITS) ? MAX_CODE_BITS : VALUE_BITS;
   localparam int FILL_BITS        = 3;
   localparam int ACC_BITS         = BYTE_BITS - 1 + VALUE_BITS;
   localparam int NBITS_BITS       = 5;
   localparam int BCNT_BITS        = 2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // bytes of one code, hi goes out first when count is two
   typedef struct packed {
      logic [BYTE_BITS-1:0] hi;
      logic [BYTE_BITS-1:0] lo;
      logic [BCNT_BITS-1:0] count;
   } vcp_entry_type;

   // queue handshake toward the consumer side
   typedef struct packed {
      logic          valid;
      vcp_entry_type data;
   } vcp_pop_type;

endpackage

`default_nettype wire

>>> rtl/vcp_if.sv
// ----------------------------------------------------------------------------
// vcp_if
// Valid/ready channels of the code packer: code input and byte output.
// ----------------------------------------------------------------------------
`default_nettype none

interface vcp_req_if import vcp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [VALUE_BITS-1:0]       code_value;
   logic [WIDTH_FIELD_BITS-1:0] code_width;

   modport source (output valid, output code_value, output code_width, input ready);
   modport sink   (input valid, input code_value, input code_width, output ready);
endinterface

interface vcp_rsp_if import vcp_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_BITS-1:0] byte_out;
   logic                 last_byte;

   modport source (output valid, output byte_out, output last_byte, input ready);
   modport sink   (input valid, input byte_out, input last_byte, output ready);
endinterface

`default_nettype wire

>>> rtl/variable_width_code_packer_unit.sv
// ----------------------------------------------------------------------------
// variable_width_code_packer_unit
// Packs variable-width codes MSB first into a byte stream.
//
// req_bus carries one code per beat: code_value and code_width (1..16;
// wider values saturate to 16, zero appends nothing). Only the low
// code_width bits of code_value are used. rsp_bus carries the bytes that
// become full, earliest bit in bit 7; last_byte marks the final byte of
// each code. A code may give zero, one or two bytes; a final partial byte
// is never flushed.
// The first byte of a code passes through the queue, the hold register and
// the output register before it shows on rsp_bus. Throughput is set by the
// output stage, one byte per cycle while rsp_bus is ready.
// A two-entry queue between input and output absorbs short stalls; when
// rsp_bus is held off the queue fills and req_bus.ready drops.
// Reset clears the partial byte to empty (eight free bits), the queue and
// the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module variable_width_code_packer_unit import vcp_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   vcp_req_if.sink    req_bus,
   vcp_rsp_if.source  rsp_bus
);

   logic          push_valid;
   logic          push_ready;
   vcp_entry_type push_data;
   vcp_pop_type   pop;
   logic          pop_ready;

   vcp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   vcp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   vcp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop       (pop),
      .pop_ready (pop_ready),
      .rsp       (rsp_bus)
   );

endmodule

`default_nettype wire

>>> rtl/vcp_front.sv
// ----------------------------------------------------------------------------
// vcp_front
// Takes code beats, appends them to the partial byte and queues full bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module vcp_front import vcp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   vcp_req_if.sink            req,
   output      logic          push_valid,
   output      vcp_entry_type push_data,
   input  wire logic          push_ready
);

   logic [BYTE_BITS-1:0]        partial_ff, partial_in;
   logic [FILL_BITS-1:0]        filled_ff, filled_in;
   logic [WIDTH_FIELD_BITS-1:0] width_sat;
   logic [VALUE_BITS:0]         code_mask;
   logic [VALUE_BITS-1:0]       code_masked;
   logic [ACC_BITS-1:0]         acc;
   logic [ACC_BITS-1:0]         aligned;
   logic [NBITS_BITS-1:0]       nbits;
   logic [BYTE_BITS:0]          keep_mask;
   logic [BYTE_BITS:0]          fill_mask;
   logic                        accept;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;

   always_comb begin
      if (req.code_width > WIDTH_FIELD_BITS'(WIDTH_LIMIT)) begin
         width_sat = WIDTH_FIELD_BITS'(WIDTH_LIMIT);
      end else begin
         width_sat = req.code_width;
      end
      code_mask   = ((VALUE_BITS+1)'(1) << width_sat) - (VALUE_BITS+1)'(1);
      code_masked = req.code_value & code_mask[VALUE_BITS-1:0];
      acc         = (ACC_BITS'(partial_ff) << width_sat) | ACC_BITS'(code_masked);
      nbits       = NBITS_BITS'(filled_ff) + NBITS_BITS'(width_sat);
      aligned     = acc >> nbits[FILL_BITS-1:0];
      keep_mask   = ((BYTE_BITS+1)'(1) << nbits[FILL_BITS-1:0]) - (BYTE_BITS+1)'(1);
      fill_mask   = ((BYTE_BITS+1)'(1) << filled_ff) - (BYTE_BITS+1)'(1);
   end

   always_comb begin
      push_data.hi    = aligned[2*BYTE_BITS-1:BYTE_BITS];
      push_data.lo    = aligned[BYTE_BITS-1:0];
      push_data.count = nbits[NBITS_BITS-1:FILL_BITS];
      push_valid      = accept && (nbits[NBITS_BITS-1:FILL_BITS] != '0);
   end

   always_comb begin
      partial_in = partial_ff;
      filled_in  = filled_ff;
      if (accept) begin
         partial_in = acc[BYTE_BITS-1:0] & keep_mask[BYTE_BITS-1:0];
         filled_in  = nbits[FILL_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         filled_ff  <= '0;
      end else begin
         partial_ff <= partial_in;
         filled_ff  <= filled_in;
      end
   end

   // bits above the fill level stay clear, the shift relies on it
   a_partial_clean: assert property (@(posedge clock) disable iff (reset)
      (partial_ff & ~fill_mask[BYTE_BITS-1:0]) == '0)
      else $error("partial byte holds bits above fill level");

endmodule

`default_nettype wire

>>> rtl/vcp_queue.sv
// ----------------------------------------------------------------------------
// vcp_queue
// Short register queue of byte groups between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module vcp_queue import vcp_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push_valid,
   input  wire vcp_entry_type push_data,
   output      logic          push_ready,
   output      vcp_pop_type   pop,
   input  wire logic          pop_ready
);

   vcp_entry_type          entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop.valid  = (count_ff != '0);
   assign pop.data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> push_ready)
      else $error("push into full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_BITS'(QUEUE_DEPTH))
      else $error("queue count out of range");

endmodule

`default_nettype wire

>>> rtl/vcp_back.sv
// ----------------------------------------------------------------------------
// vcp_back
// Drains queued byte groups onto the output channel, one beat a cycle while rsp.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module vcp_back import vcp_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire vcp_pop_type pop,
   output      logic        pop_ready,
   vcp_rsp_if.source        rsp
);

   logic [BYTE_BITS-1:0] hold_hi_ff, hold_lo_ff;
   logic [BCNT_BITS-1:0] hold_cnt_ff;
   logic                 rsp_valid_ff;
   logic [BYTE_BITS-1:0] rsp_byte_ff;
   logic                 rsp_last_ff;
   logic                 out_load;

   assign out_load  = (!rsp_valid_ff || rsp.ready) && (hold_cnt_ff != '0);
   assign pop_ready = (hold_cnt_ff == '0) ||
                      (out_load && (hold_cnt_ff == BCNT_BITS'(1)));

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.byte_out  = rsp_byte_ff;
   assign rsp.last_byte = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop.valid && pop_ready) begin
            hold_cnt_ff <= pop.data.count;
         end else if (out_load) begin
            hold_cnt_ff <= hold_cnt_ff - 1'b1;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop.valid && pop_ready) begin
         hold_hi_ff <= pop.data.hi;
         hold_lo_ff <= pop.data.lo;
      end
      if (out_load) begin
         rsp_byte_ff <= (hold_cnt_ff == BCNT_BITS'(2)) ? hold_hi_ff : hold_lo_ff;
         rsp_last_ff <= (hold_cnt_ff == BCNT_BITS'(1));
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      hold_cnt_ff != BCNT_BITS'(3))
      else $error("hold count out of range");

   // a non-last beat always has its partner byte still held
   a_partner_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_last_ff) |-> (hold_cnt_ff == BCNT_BITS'(1)))
      else $error("first byte out without second byte held");

endmodule

`default_nettype wire

>>> tb/variable_width_code_packer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// variable_width_code_packer_unit_test
// Self-checking bench for the MSB-first variable-width code packer.
//
// Codes go in on req_bus, and bytes come back on rsp_bus. A directed table
// covers the field extremes, a zero width, saturating widths and masked high
// bits. A long random run follows. Bytes of typed rows are checked against
// the table, all other bytes against a bit-level packing model in the bench.
// The run has phases with no idling, sender gaps, receiver stalls, and both.
// ----------------------------------------------------------------------------

module variable_width_code_packer_unit_test;
   import vcp_pkg::*;

   localparam int NUM_ROWS     = 23;
   localparam int RANDOM_CODES = 1500;
   localparam int PHASE_CODES  = RANDOM_CODES / 4;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct packed {
      logic [BYTE_BITS-1:0] data;
      logic                 last;
   } out_byte_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0]       value;
      logic [WIDTH_FIELD_BITS-1:0] width;
      logic                        typed;
      logic [1:0]                  nbytes;
      logic [BYTE_BITS-1:0]        first_byte;
      logic [BYTE_BITS-1:0]        second_byte;
   } code_row_type;

   logic clock = 1'b0;
   logic reset;

   vcp_req_if req_bus ();
   vcp_rsp_if rsp_bus ();

   variable_width_code_packer_unit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #5 clock = ~clock;

   // packing state of the model: gathered bits right-aligned
   logic [BYTE_BITS-1:0] packed_bits;
   logic [3:0]           free_slots;
   out_byte_type         pending_bytes [$];

   int send_idle  = 0;
   int recv_stall = 0;
   int errors     = 0;
   int cycle_count = 0;

   code_row_type directed_rows [NUM_ROWS] = '{
      '{16'hFFFF, 5'd8,  1'b1, 2'd1, 8'hFF, 8'h00},
      '{16'h0000, 5'd16, 1'b1, 2'd2, 8'h00, 8'h00},
      '{16'hABCD, 5'd16, 1'b1, 2'd2, 8'hAB, 8'hCD},
      '{16'hFFFF, 5'd0,  1'b1, 2'd0, 8'h00, 8'h00},
      '{16'h1234, 5'd31, 1'b1, 2'd2, 8'h12, 8'h34},
      '{16'hFF01, 5'd1,  1'b1, 2'd0, 8'h00, 8'h00},
      '{16'h0000, 5'd7,  1'b1, 2'd1, 8'h80, 8'h00},
      '{16'hFFFE, 5'd3,  1'b1, 2'd0, 8'h00, 8'h00},
      '{16'h5A5A, 5'd16, 1'b0, 2'd0, 8'h00, 8'h00},
      '{16'hFFFF, 5'd17, 1'b0, 2'd0, 8'h00, 8'h00},
      '{16'hFFE0, 5'd5,  1'b0, 2'd0, 8'h00, 8'h00},
      '{16'hFFFF, 5'd0,  1'b0, 2'd0, 8'h00, 8'h00},
      '{16'h0001, 5'd1,  1'b0, 2'd0, 8'h00, 8'h00},
      '{16'h7FFF, 5'd15, 1'b0, 2'd0, 8'h00, 8'h00},
      '{16'h0155, 5'd9,  1'b0, 2'd0, 8'h00, 8'h00},
      '{16'h8000, 5'd16, 1'b0, 2'd0, 8'h00, 8'h00},
      '{16'hFFFF, 5'd2,  1'b0, 2'd0, 8'h00, 8'h00},
      '{16'h0000, 5'd24, 1'b0, 2'd0, 8'h00, 8'h00},
      '{16'h000F, 5'd4,  1'b0, 2'd0, 8'h00, 8'h00},
      '{16'hFFFF, 5'd16, 1'b0, 2'd0, 8'h00, 8'h00},
      '{16'h0003, 5'd2,  1'b0, 2'd0, 8'h00, 8'h00},
      '{16'h00AA, 5'd8,  1'b0, 2'd0, 8'h00, 8'h00},
      '{16'h002B, 5'd6,  1'b0, 2'd0, 8'h00, 8'h00}
   };

   function automatic void queue_byte(input logic [BYTE_BITS-1:0] data, input logic last);
      out_byte_type b;
      b.data = data;
      b.last = last;
      pending_bytes.push_back(b);
   endfunction

   // appends one code MSB first, queues the bytes it completes when record is set
   function automatic void pack_code(input logic [VALUE_BITS-1:0] value,
                                     input logic [WIDTH_FIELD_BITS-1:0] width,
                                     input bit record);
      int w;
      int nbits;
      int count;
      logic [31:0] acc;
      logic [BYTE_BITS-1:0] done [2];
      w = (width > WIDTH_LIMIT) ? WIDTH_LIMIT : int'(width);
      count = 0;
      if (w == 0) return;
      nbits = BYTE_BITS - int'(free_slots);
      acc = ({24'd0, packed_bits} << w) | ({16'd0, value} & ((32'd1 << w) - 32'd1));
      nbits = nbits + w;
      while (nbits >= BYTE_BITS && count < 2) begin
         nbits = nbits - BYTE_BITS;
         done[count] = acc[nbits +: BYTE_BITS];
         acc = acc & ((32'd1 << nbits) - 32'd1);
         count++;
      end
      if (record) begin
         for (int i = 0; i < count; i++) queue_byte(done[i], i == count - 1);
      end
      packed_bits = acc[BYTE_BITS-1:0];
      free_slots = 4'(BYTE_BITS - nbits);
   endfunction

   // returns at the edge that accepts the beat
   task automatic send_code(input logic [VALUE_BITS-1:0] value,
                            input logic [WIDTH_FIELD_BITS-1:0] width);
      if ($urandom_range(99) < send_idle) begin
         req_bus.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_bus.valid      <= 1'b1;
      req_bus.code_value <= value;
      req_bus.code_width <= width;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // byte checker and receiver stalls
   initial begin
      out_byte_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_bus.ready <= 1'b0;
         end else begin
            if (rsp_bus.valid && rsp_bus.ready) begin
               if (pending_bytes.size() == 0) begin
                  errors++;
                  $display("%0t: unexpected beat byte_out=%h last_byte=%b", $time,
                           rsp_bus.byte_out, rsp_bus.last_byte);
               end else begin
                  want = pending_bytes.pop_front();
                  if (rsp_bus.byte_out !== want.data) begin
                     errors++;
                     $display("%0t: byte_out expected %h actual %h", $time,
                              want.data, rsp_bus.byte_out);
                  end
                  if (rsp_bus.last_byte !== want.last) begin
                     errors++;
                     $display("%0t: last_byte expected %b actual %b", $time,
                              want.last, rsp_bus.last_byte);
                  end
               end
            end
            rsp_bus.ready <= ($urandom_range(99) >= recv_stall);
         end
      end
   end

   initial begin
      logic [VALUE_BITS-1:0]       value;
      logic [WIDTH_FIELD_BITS-1:0] width;
      int pick;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.code_value = '0;
      req_bus.code_width = '0;
      packed_bits        = '0;
      free_slots         = 4'(BYTE_BITS);
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_code(directed_rows[i].value, directed_rows[i].width);
         if (directed_rows[i].typed) begin
            if (directed_rows[i].nbytes >= 1)
               queue_byte(directed_rows[i].first_byte, directed_rows[i].nbytes == 1);
            if (directed_rows[i].nbytes == 2)
               queue_byte(directed_rows[i].second_byte, 1'b1);
            pack_code(directed_rows[i].value, directed_rows[i].width, 1'b0);
         end else begin
            pack_code(directed_rows[i].value, directed_rows[i].width, 1'b1);
         end
      end

      for (int k = 0; k < RANDOM_CODES; k++) begin
         case (k / PHASE_CODES)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 65; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 65; end
            default: begin send_idle = 34; recv_stall = 34; end
         endcase
         pick  = $urandom_range(99);
         value = VALUE_BITS'($urandom);
         if (pick < 5)
            width = '0;
         else if (pick < 10)
            width = WIDTH_FIELD_BITS'($urandom_range(31, WIDTH_LIMIT + 1));
         else if (pick < 15)
            width = WIDTH_FIELD_BITS'(WIDTH_LIMIT);
         else
            width = WIDTH_FIELD_BITS'($urandom_range(WIDTH_LIMIT, 1));
         send_code(value, width);
         pack_code(value, width, 1'b1);
      end

      req_bus.valid <= 1'b0;
      recv_stall = 0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
